>>> sv/gimc_pkg.sv
package gimc_pkg;

   localparam int MAX_POSITIONS_DEF = 64;
   localparam int MAX_SPANS_DEF     = 64;

   localparam int FUNC_W   = 2;
   localparam int DEMAND_W = 8;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DEMAND = 2'd0,
      FUNC_SPAN   = 2'd1,
      FUNC_RUN    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

endpackage

>>> sv/greedy_interval_multicover_unit.sv
// greedy interval multicover, furthest end first
//
// req channel: one item per transfer. func demand appends a demand to the
// position row, func span appends an interval (start, end); both are taken
// one per cycle while no run holds req_stall, and give no result. func run
// sweeps the row, picks intervals greedily, then clears the row and intervals.
// rsp channel: one transfer per run with removable_count and failed.
//
// a run holds req_stall high while it sweeps the positions (stopping early
// on a failing position) and picks intervals: each pick is a linear
// search through the interval memory, one entry per cycle through its
// single read port. the result shows up as req_stall drops.
// the result sits in an output register; while rsp_stall is high it is
// held, and load items are still accepted. a following run waits for the
// held result to transfer before it reports.
// reset empties the row and the interval set and drops any held result.
module greedy_interval_multicover_unit #(
   parameter int MAX_POSITIONS = gimc_pkg::MAX_POSITIONS_DEF,
   parameter int MAX_SPANS     = gimc_pkg::MAX_SPANS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gimc_pkg::FUNC_W-1:0]   req_func,
   input  logic [gimc_pkg::DEMAND_W-1:0] req_demand,
   input  logic [gimc_pkg::POS_W-1:0]    req_span_start,
   input  logic [gimc_pkg::POS_W-1:0]    req_span_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gimc_pkg::COUNT_W-1:0]  rsp_removable_count,
   output logic                          rsp_failed
);

   localparam int CW  = $clog2(MAX_POSITIONS + 1);
   localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int SCW = $clog2(MAX_SPANS + 1);
   localparam int SPW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int DCW = SCW;
   localparam int XW  = (CW > gimc_pkg::POS_W) ? CW : gimc_pkg::POS_W;
   localparam int AW  = (CW > gimc_pkg::POS_W + 1) ? CW : gimc_pkg::POS_W + 1;
   localparam int PSW = gimc_pkg::POS_W;
   localparam int SWW = 2 * PSW + 1;
   localparam int DW  = gimc_pkg::DEMAND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_DEM,
      ST_CHECK,
      ST_SCAN,
      ST_TAKE,
      ST_DROP,
      ST_DONE
   } state_type;

   // span word: taken flag, end, start
   logic [SWW-1:0] span_mem [MAX_SPANS];
   logic [DW-1:0]  dem_mem  [MAX_POSITIONS];
   logic [DCW-1:0] drop_mem [MAX_POSITIONS];

   logic [SWW-1:0] span_rd_ff;
   logic [DW-1:0]  dem_rd_ff;
   logic [DCW-1:0] drop_rd_ff;

   state_type      state_ff, state_in;
   logic [CW-1:0]  pos_count_ff, pos_count_in;
   logic [SCW-1:0] span_count_ff, span_count_in;
   logic [DW-1:0]  cov_ff, cov_in;
   logic [DW-1:0]  need_ff, need_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [SCW-1:0] issue_ff, issue_in;
   logic           pend_ff, pend_in;
   logic [SPW-1:0] rd_idx_ff, rd_idx_in;
   logic           best_valid_ff, best_valid_in;
   logic [SPW-1:0] best_idx_ff, best_idx_in;
   logic [2*PSW-1:0] best_word_ff, best_word_in;
   logic [SCW-1:0] taken_ff, taken_in;
   logic           fail_ff, fail_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [gimc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic           rsp_failed_ff, rsp_failed_in;

   logic           span_we, span_re;
   logic [SPW-1:0] span_waddr, span_raddr;
   logic [SWW-1:0] span_wdata;
   logic           dem_we, dem_re;
   logic [PW-1:0]  dem_waddr;
   logic           drop_we, drop_re;
   logic [PW-1:0]  drop_waddr, drop_raddr;
   logic [DCW-1:0] drop_wdata;

   logic           req_xfer;
   logic [PSW-1:0] scan_start, scan_end;
   logic           scan_hit;
   logic [AW-1:0]  drop_at;
   logic           drop_ok;
   logic           issue_more;
   logic           out_free;

   assign req_xfer   = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign scan_start = span_rd_ff[PSW-1:0];
   assign scan_end   = span_rd_ff[2*PSW-1:PSW];
   assign scan_hit   = !span_rd_ff[2*PSW]
                       && (XW'(scan_start) <= XW'(pos_ff))
                       && (XW'(scan_end) >= XW'(pos_ff))
                       && (!best_valid_ff || (scan_end > best_word_ff[2*PSW-1:PSW]));
   assign drop_at    = AW'(best_word_ff[2*PSW-1:PSW]) + AW'(1);
   assign drop_ok    = drop_at < AW'(MAX_POSITIONS);
   assign issue_more = issue_ff < span_count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      pos_count_in  = pos_count_ff;
      span_count_in = span_count_ff;
      cov_in        = cov_ff;
      need_in       = need_ff;
      pos_in        = pos_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      taken_in      = taken_ff;
      fail_in       = fail_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_failed_in = rsp_failed_ff;

      span_we    = 1'b0;
      span_waddr = span_count_ff[SPW-1:0];
      span_wdata = {1'b0, req_span_end, req_span_start};
      span_re    = 1'b0;
      span_raddr = issue_ff[SPW-1:0];
      dem_we     = 1'b0;
      dem_waddr  = pos_count_ff[PW-1:0];
      dem_re     = 1'b0;
      drop_we    = 1'b0;
      drop_waddr = pos_count_ff[PW-1:0];
      drop_wdata = '0;
      drop_re    = 1'b0;
      drop_raddr = pos_ff[PW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (gimc_pkg::func_type'(req_func))
                  gimc_pkg::FUNC_DEMAND: begin
                     // clear the drop slot as the position is loaded
                     if (pos_count_ff < CW'(MAX_POSITIONS)) begin
                        dem_we       = 1'b1;
                        drop_we      = 1'b1;
                        pos_count_in = pos_count_ff + CW'(1);
                     end
                  end
                  gimc_pkg::FUNC_SPAN: begin
                     if (span_count_ff < SCW'(MAX_SPANS)) begin
                        span_we       = 1'b1;
                        span_count_in = span_count_ff + SCW'(1);
                     end
                  end
                  gimc_pkg::FUNC_RUN: begin
                     pos_in   = '0;
                     taken_in = '0;
                     fail_in  = 1'b0;
                     if (pos_count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_POS;
                     end
                  end
                  gimc_pkg::FUNC_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POS: begin
            dem_re     = 1'b1;
            drop_re    = 1'b1;
            drop_raddr = pos_ff[PW-1:0];
            state_in   = ST_DEM;
         end
         ST_DEM: begin
            cov_in   = cov_ff - DW'(drop_rd_ff);
            need_in  = dem_rd_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cov_ff < need_ff) begin
               issue_in      = '0;
               best_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end else if (pos_ff + CW'(1) == pos_count_ff) begin
               state_in = ST_DONE;
            end else begin
               pos_in   = pos_ff + CW'(1);
               state_in = ST_POS;
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               span_re   = 1'b1;
               issue_in  = issue_ff + SCW'(1);
               rd_idx_in = issue_ff[SPW-1:0];
               pend_in   = 1'b1;
            end
            if (pend_ff && scan_hit) begin
               best_valid_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_word_in  = span_rd_ff[2*PSW-1:0];
            end
            if (!issue_more && !pend_ff) begin
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            if (!best_valid_ff) begin
               fail_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               span_we    = 1'b1;
               span_waddr = best_idx_ff;
               span_wdata = {1'b1, best_word_ff};
               cov_in     = cov_ff + DW'(1);
               taken_in   = taken_ff + SCW'(1);
               if (drop_ok) begin
                  drop_re    = 1'b1;
                  drop_raddr = drop_at[PW-1:0];
                  state_in   = ST_DROP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DROP: begin
            drop_we    = 1'b1;
            drop_waddr = drop_at[PW-1:0];
            drop_wdata = drop_rd_ff + DCW'(1);
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_failed_in = fail_ff;
               rsp_count_in  = fail_ff ? '0
                               : gimc_pkg::COUNT_W'(span_count_ff - taken_ff);
               pos_count_in  = '0;
               span_count_in = '0;
               cov_in        = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_count_ff  <= '0;
         span_count_ff <= '0;
         cov_ff        <= '0;
         pend_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_count_ff  <= pos_count_in;
         span_count_ff <= span_count_in;
         cov_ff        <= cov_in;
         pend_ff       <= pend_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      need_ff       <= need_in;
      pos_ff        <= pos_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_word_ff  <= best_word_in;
      taken_ff      <= taken_in;
      fail_ff       <= fail_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   always_ff @(posedge clock) begin
      if (span_we) begin
         span_mem[span_waddr] <= span_wdata;
      end
      if (span_re) begin
         span_rd_ff <= span_mem[span_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dem_we) begin
         dem_mem[dem_waddr] <= req_demand;
      end
      if (dem_re) begin
         dem_rd_ff <= dem_mem[pos_ff[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (drop_we) begin
         drop_mem[drop_waddr] <= drop_wdata;
      end
      if (drop_re) begin
         drop_rd_ff <= drop_mem[drop_raddr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_removable_count = rsp_count_ff;
   assign rsp_failed          = rsp_failed_ff;

endmodule

>>> sv/gimc_checker.sv
module gimc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [gimc_pkg::FUNC_W-1:0]   req_func,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gimc_pkg::COUNT_W-1:0]  rsp_removable_count,
   input logic                          rsp_failed
);

   // a held result does not move
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_removable_count) && $stable(rsp_failed))
      else $error("held result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_removable_count == '0)
      else $error("failed result with nonzero count");

   // a run transfer always holds off further input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == gimc_pkg::FUNC_RUN |=> req_stall)
      else $error("run did not hold off input");

   // a new result only comes out of a run
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a sweep");

endmodule

bind greedy_interval_multicover_unit gimc_checker u_gimc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_func            (req_func),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_removable_count (rsp_removable_count),
   .rsp_failed          (rsp_failed)
);
